// ===== hw/rtl/fmrf_pkg.sv =====
`default_nettype none

package fmrf_pkg;

  localparam int SlotW = 6;
  localparam int TtlW  = 4;

  localparam logic [31:0]     MagicReset = 32'h5373_4d65;
  localparam logic [TtlW-1:0] TtlReset   = 4'd4;

  typedef logic [0:0] cfg_index_t;

  localparam cfg_index_t CfgMagic = 1'd0;
  localparam cfg_index_t CfgTtl   = 1'd1;

  localparam logic [1:0] OpRx    = 2'd0;
  localparam logic [1:0] OpLocal = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [7:0] KindMessage = 8'd1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              length_ok;
    logic [31:0]       pkt_magic;
    logic [7:0]        pkt_kind;
    logic [7:0]        hop_count;
    logic [31:0]       msg_id;
    logic [47:0]       src_mac;
    logic              from_self;
    logic signed [7:0] signal_level;
    logic [47:0]       now_time;
  } in_word_t;

  typedef struct packed {
    logic             accepted;
    logic [SlotW-1:0] peer_slot;
    logic             peer_replaced;
    logic             duplicate;
    logic             deliver;
    logic [SlotW-1:0] inbox_slot;
    logic             relay;
    logic [TtlW-1:0]  relay_ttl;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/flood_mesh_receive_filter.sv =====
// Receive filter of a flooding mesh node.
// The input channel (in_valid_i, in_stall_o, in_word_i) takes one word per
// received packet, locally originated id or inbox clear. The output channel
// (out_valid_o, out_stall_i, out_word_o) returns exactly one result word for
// each input word, in order. The configuration channel writes the magic word
// (index 0) and the hop limit (index 1) and is always ready.
// One word is worked on at a time by a small sequencer that steps through
// the tables one entry at a time. A received packet that passes the checks
// scans the peer table, scans timestamps for eviction when the table is full,
// writes the peer entry, scans the recent-id ring (skipped for a zero id) and
// finishes, after the accept state. A rejected packet or an inbox clear goes
// straight to the finish state; a local id scans the ring first.
// Reset clears the id ring, the peer count, the inbox pointers and restores
// the configuration defaults. A finished result waits in the output register
// while the receiver stalls; the next word is accepted meanwhile and its
// work proceeds until it, too, has to hand over its result.
`default_nettype none

module flood_mesh_receive_filter #(
  parameter int SEEN_DEPTH  = 32,
  parameter int PEER_DEPTH  = 12,
  parameter int INBOX_DEPTH = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire fmrf_pkg::in_word_t    in_word_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output fmrf_pkg::out_word_t        out_word_o,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire fmrf_pkg::cfg_index_t  cfg_index_i,
  input  wire [31:0]                 cfg_data_i
);
  import fmrf_pkg::*;

  localparam int SeenW   = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int PeerW   = (PEER_DEPTH > 1) ? $clog2(PEER_DEPTH) : 1;
  localparam int InboxW  = (INBOX_DEPTH > 1) ? $clog2(INBOX_DEPTH) : 1;
  localparam int ScanMax = (SEEN_DEPTH > PEER_DEPTH) ? SEEN_DEPTH : PEER_DEPTH;
  localparam int IdxW    = $clog2(ScanMax + 1);
  localparam int CntW    = $clog2(PEER_DEPTH + 1);
  localparam int FillW   = $clog2(INBOX_DEPTH + 1);

  localparam logic [IdxW-1:0]   SeenLast  = IdxW'(SEEN_DEPTH - 1);
  localparam logic [IdxW-1:0]   PeerLast  = IdxW'(PEER_DEPTH - 1);
  localparam logic [CntW-1:0]   PeerFull  = CntW'(PEER_DEPTH);
  localparam logic [SeenW-1:0]  HeadLast  = SeenW'(SEEN_DEPTH - 1);
  localparam logic [InboxW-1:0] InboxLast = InboxW'(INBOX_DEPTH - 1);
  localparam logic [FillW-1:0]  FillFull  = FillW'(INBOX_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PEER  = 3'd1;
  localparam logic [2:0] S_EVICT = 3'd2;
  localparam logic [2:0] S_PWR   = 3'd3;
  localparam logic [2:0] S_RING  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  in_word_t          item_q, item_d;
  logic              acc_q, acc_d;
  logic [PeerW-1:0]  slot_q, slot_d;
  logic              found_q, found_d;
  logic              replaced_q, replaced_d;
  logic              dup_q, dup_d;
  logic [47:0]       best_q, best_d;
  logic [31:0]       magic_q, magic_d;
  logic [TtlW-1:0]   ttl_q, ttl_d;
  logic [SeenW-1:0]  recent_head_q, recent_head_d;
  logic [CntW-1:0]   peer_count_q, peer_count_d;
  logic [InboxW-1:0] inbox_head_q, inbox_head_d;
  logic [FillW-1:0]  inbox_fill_q, inbox_fill_d;
  logic [31:0]       msg_total_q, msg_total_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  logic [31:0] recent_ids_q [SEEN_DEPTH];
  logic [47:0] peer_addr_q  [PEER_DEPTH];
  logic [47:0] peer_time_q  [PEER_DEPTH];
  logic [7:0]  peer_sig_q   [PEER_DEPTH];

  logic            ring_we;
  logic            peer_we;
  logic            ring_hit;
  logic            peer_hit;
  logic            older;
  logic            deliver;
  logic [TtlW-1:0] ttl_clamp;
  out_word_t       res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign ring_hit = (recent_ids_q[idx_q[SeenW-1:0]] == item_q.msg_id);
  assign peer_hit = (peer_addr_q[idx_q[PeerW-1:0]] == item_q.src_mac);
  assign older    = (peer_time_q[idx_q[PeerW-1:0]] < best_q);

  assign ttl_clamp = (item_q.hop_count > {4'd0, ttl_q}) ? ttl_q : item_q.hop_count[TtlW-1:0];
  assign deliver   = acc_q && (item_q.pkt_kind == KindMessage) && !dup_q;

  always_comb begin
    res               = '0;
    res.accepted      = acc_q;
    res.peer_slot     = acc_q ? SlotW'(slot_q) : '0;
    res.peer_replaced = replaced_q;
    res.duplicate     = dup_q;
    res.deliver       = deliver;
    if (deliver) begin
      res.inbox_slot = SlotW'(inbox_head_q);
      if (ttl_clamp > 4'd1) begin
        res.relay     = 1'b1;
        res.relay_ttl = ttl_clamp - 4'd1;
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    item_d        = item_q;
    acc_d         = acc_q;
    slot_d        = slot_q;
    found_d       = found_q;
    replaced_d    = replaced_q;
    dup_d         = dup_q;
    best_d        = best_q;
    magic_d       = magic_q;
    ttl_d         = ttl_q;
    recent_head_d = recent_head_q;
    peer_count_d  = peer_count_q;
    inbox_head_d  = inbox_head_q;
    inbox_fill_d  = inbox_fill_q;
    msg_total_d   = msg_total_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_word_d    = out_word_q;
    ring_we       = 1'b0;
    peer_we       = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMagic: magic_d = cfg_data_i;
        CfgTtl:   ttl_d   = cfg_data_i[TtlW-1:0];
        default:  ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d     = in_word_i;
          idx_d      = '0;
          found_d    = 1'b0;
          replaced_d = 1'b0;
          dup_d      = 1'b0;
          acc_d      = (in_word_i.opcode == OpRx) && in_word_i.length_ok &&
                       (in_word_i.pkt_magic == magic_q) && !in_word_i.from_self;
          if ((in_word_i.opcode == OpRx) && acc_d) begin
            state_d = S_PEER;
          end else if (in_word_i.opcode == OpLocal) begin
            state_d = S_RING;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_PEER: begin
        if (idx_q == IdxW'(peer_count_q)) begin
          if (peer_count_q == PeerFull) begin
            idx_d   = '0;
            state_d = S_EVICT;
          end else begin
            slot_d       = PeerW'(peer_count_q);
            peer_count_d = peer_count_q + 1'b1;
            state_d      = S_PWR;
          end
        end else if (peer_hit) begin
          slot_d  = idx_q[PeerW-1:0];
          found_d = 1'b1;
          state_d = S_PWR;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_EVICT: begin
        if ((idx_q == '0) || older) begin
          best_d = peer_time_q[idx_q[PeerW-1:0]];
          slot_d = idx_q[PeerW-1:0];
        end
        if (idx_q == PeerLast) begin
          replaced_d = 1'b1;
          state_d    = S_PWR;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_PWR: begin
        peer_we = 1'b1;
        idx_d   = '0;
        state_d = (item_q.msg_id != '0) ? S_RING : S_FIN;
      end
      S_RING: begin
        if (ring_hit) begin
          dup_d   = 1'b1;
          state_d = S_FIN;
        end else if (idx_q == SeenLast) begin
          ring_we       = 1'b1;
          recent_head_d = (recent_head_q == HeadLast) ? '0 : recent_head_q + 1'b1;
          state_d       = S_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d  = res;
          if (deliver) begin
            msg_total_d  = msg_total_q + 32'd1;
            inbox_head_d = (inbox_head_q == InboxLast) ? '0 : inbox_head_q + 1'b1;
            if (inbox_fill_q != FillFull) begin
              inbox_fill_d = inbox_fill_q + 1'b1;
            end
          end
          if (item_q.opcode == OpClear) begin
            inbox_fill_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      magic_q       <= MagicReset;
      ttl_q         <= TtlReset;
      recent_head_q <= '0;
      peer_count_q  <= '0;
      inbox_head_q  <= '0;
      inbox_fill_q  <= '0;
      msg_total_q   <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < SEEN_DEPTH; i++) begin
        recent_ids_q[i] <= '0;
      end
    end else begin
      state_q       <= state_d;
      magic_q       <= magic_d;
      ttl_q         <= ttl_d;
      recent_head_q <= recent_head_d;
      peer_count_q  <= peer_count_d;
      inbox_head_q  <= inbox_head_d;
      inbox_fill_q  <= inbox_fill_d;
      msg_total_q   <= msg_total_d;
      out_valid_q   <= out_valid_d;
      if (ring_we) begin
        recent_ids_q[recent_head_q] <= item_q.msg_id;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    item_q     <= item_d;
    acc_q      <= acc_d;
    slot_q     <= slot_d;
    found_q    <= found_d;
    replaced_q <= replaced_d;
    dup_q      <= dup_d;
    best_q     <= best_d;
    out_word_q <= out_word_d;
    if (peer_we) begin
      if (!found_q) begin
        peer_addr_q[slot_q] <= item_q.src_mac;
      end
      peer_time_q[slot_q] <= item_q.now_time;
      peer_sig_q[slot_q]  <= item_q.signal_level;
    end
  end

  a_peer_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peer_count_q <= PeerFull)
    else $error("peer count exceeds table depth");

  a_inbox_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inbox_fill_q <= FillFull)
    else $error("inbox fill exceeds inbox depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && out_valid_q && out_stall_i |=>
      out_valid_q && $stable(out_word_q))
    else $error("pending result overwritten");

  a_deliver_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.deliver |-> out_word_q.accepted && !out_word_q.duplicate)
    else $error("delivery of a rejected or duplicate word");

  a_relay_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.relay |-> out_word_q.deliver && (out_word_q.relay_ttl != '0))
    else $error("relay without delivery");

endmodule

`default_nettype wire
